@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ hw/rtl/pdlc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdlc_pkg
// Types and codes of the password door lock controller.
// ----------------------------------------------------------------------------
package pdlc_pkg;

    // Input word
    typedef struct packed {
        logic [1:0]  mode;
        logic [39:0] password_first;
        logic [39:0] password_second;
        logic [1:0]  choice;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [1:0] reply;
        logic [1:0] motor_direction;
        logic [7:0] motor_speed;
        logic       alarm_sounding;
        logic       enrolled_flag;
    } t_out_word;

    // Door sequence
    typedef enum logic [1:0] {
        DOOR_IDLE   = 2'd0,
        DOOR_UNLOCK = 2'd1,
        DOOR_HOLD   = 2'd2,
        DOOR_LOCK   = 2'd3
    } t_door_phase;

    localparam int unsigned KEY_FIELD_BITS = 40;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_ENROLL  = 2'd1;
    localparam logic [1:0] MODE_ATTEMPT = 2'd2;

    localparam logic [1:0] CHOICE_OPEN   = 2'd0;
    localparam logic [1:0] CHOICE_CHANGE = 2'd1;

    localparam logic [1:0] REPLY_NONE    = 2'd0;
    localparam logic [1:0] REPLY_CORRECT = 2'd1;
    localparam logic [1:0] REPLY_WRONG   = 2'd2;
    localparam logic [1:0] REPLY_REPEAT  = 2'd3;

    localparam logic [1:0] DIR_STOP   = 2'd0;
    localparam logic [1:0] DIR_UNLOCK = 2'd1;
    localparam logic [1:0] DIR_LOCK   = 2'd2;

    localparam logic [7:0] SPEED_STOP   = 8'd0;
    localparam logic [7:0] SPEED_UNLOCK = 8'd150;
    localparam logic [7:0] SPEED_LOCK   = 8'd100;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_UNLOCK_TICKS  = 2'd0;
    localparam logic [1:0] REG_HOLD_TICKS    = 2'd1;
    localparam logic [1:0] REG_ALARM_TICKS   = 2'd2;
    localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd3;

    localparam logic [7:0] RST_UNLOCK_TICKS  = 8'd15;
    localparam logic [7:0] RST_HOLD_TICKS    = 8'd3;
    localparam logic [7:0] RST_ALARM_TICKS   = 8'd60;
    localparam logic [2:0] RST_ATTEMPT_LIMIT = 3'd3;

    // A zero tick count or limit behaves as one.
    function automatic logic [7:0] at_least_one8(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [2:0] at_least_one3(input logic [2:0] v);
        return (v == 3'd0) ? 3'd1 : v;
    endfunction

endpackage

@@ hw/rtl/password_door_lock_controller.sv @@
// ----------------------------------------------------------------------------
// password_door_lock_controller
// Password enrollment and checking, timed door motor sequence and alarm.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//   event: a tick, an enroll pair or an entry attempt. Output channel
//   (o_out_valid / i_out_ready / o_out_word) returns exactly one result word
//   per input word, in order: the reply plus motor, buzzer and enrolled state
//   after the event.
//   A result is registered in the output register, else in the skid register.
//   Throughput: one word per cycle while o_in_ready is high; all work is a
//   single compare plus counter updates between the input handshake and
//   the output register. A two-entry output stage (output register plus
//   skid register) lets the block take one more word while a result waits;
//   o_in_ready drops only while the skid register is full, and comes back
//   the cycle after the receiver takes a word.
//   Reset (synchronous, active low) clears enrollment, counters, door and
//   alarm state and both output entries, and loads the register defaults:
//   unlock 15, hold 3, alarm 60 ticks, attempt limit 3.
//   APB registers at byte offsets 0x0, 0x4, 0x8, 0xC; write only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module password_door_lock_controller #(
    parameter int PASSWORD_LENGTH = 5   // key bytes compared, 1..5; larger values compare 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pdlc_pkg::t_in_word   i_in_word,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pdlc_pkg::t_out_word  o_out_word,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // Compared key bits: 8 per byte, capped at the 40-bit field.
    localparam int KEY_BITS = (8 * PASSWORD_LENGTH > pdlc_pkg::KEY_FIELD_BITS) ?
                              pdlc_pkg::KEY_FIELD_BITS : 8 * PASSWORD_LENGTH;

    // ---------------- configuration registers ----------------
    logic [7:0] r_unlock_ticks;
    logic [7:0] r_hold_ticks;
    logic [7:0] r_alarm_ticks;
    logic [2:0] r_attempt_limit;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlock_ticks  <= pdlc_pkg::RST_UNLOCK_TICKS;
            r_hold_ticks    <= pdlc_pkg::RST_HOLD_TICKS;
            r_alarm_ticks   <= pdlc_pkg::RST_ALARM_TICKS;
            r_attempt_limit <= pdlc_pkg::RST_ATTEMPT_LIMIT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                pdlc_pkg::REG_UNLOCK_TICKS:  r_unlock_ticks  <= pwdata[7:0];
                pdlc_pkg::REG_HOLD_TICKS:    r_hold_ticks    <= pwdata[7:0];
                pdlc_pkg::REG_ALARM_TICKS:   r_alarm_ticks   <= pwdata[7:0];
                pdlc_pkg::REG_ATTEMPT_LIMIT: r_attempt_limit <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            pdlc_pkg::REG_UNLOCK_TICKS:  prdata = {24'd0, r_unlock_ticks};
            pdlc_pkg::REG_HOLD_TICKS:    prdata = {24'd0, r_hold_ticks};
            pdlc_pkg::REG_ALARM_TICKS:   prdata = {24'd0, r_alarm_ticks};
            pdlc_pkg::REG_ATTEMPT_LIMIT: prdata = {29'd0, r_attempt_limit};
            default:                     prdata = 32'd0;
        endcase
    end

    // ---------------- lock state ----------------
    logic                  r_enrolled,     n_enrolled;
    logic [KEY_BITS-1:0]   r_stored_pw,    n_stored_pw;   // no reset, read only once enrolled
    logic [2:0]            r_miss_count,   n_miss_count;
    pdlc_pkg::t_door_phase r_door_phase,   n_door_phase;
    logic [7:0]            r_door_timer,   n_door_timer;
    logic                  r_alarm_active, n_alarm_active;
    logic [7:0]            r_alarm_timer,  n_alarm_timer;

    // ---------------- output stage ----------------
    logic                  r_out_valid;
    logic                  r_skid_valid;
    pdlc_pkg::t_out_word   r_out_word;
    pdlc_pkg::t_out_word   r_skid_word;
    pdlc_pkg::t_out_word   n_result;

    logic                  in_acc;
    logic                  out_take;

    assign o_in_ready  = !r_skid_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Per-word next state and result; the state only moves on accept.
    always_comb begin
        logic [1:0] reply;
        logic [7:0] door_dec;
        logic [7:0] alarm_dec;
        logic [2:0] miss_next;
        logic       pw_match;
        logic       key_eq;

        n_enrolled     = r_enrolled;
        n_stored_pw    = r_stored_pw;
        n_miss_count   = r_miss_count;
        n_door_phase   = r_door_phase;
        n_door_timer   = r_door_timer;
        n_alarm_active = r_alarm_active;
        n_alarm_timer  = r_alarm_timer;
        reply          = pdlc_pkg::REPLY_NONE;

        door_dec  = (r_door_timer != 8'd0) ? r_door_timer - 8'd1 : 8'd0;
        alarm_dec = (r_alarm_timer != 8'd0) ? r_alarm_timer - 8'd1 : 8'd0;
        miss_next = r_miss_count + 3'd1;   // wraps to zero like the 3-bit count
        key_eq    = (i_in_word.password_first[KEY_BITS-1:0] ==
                     i_in_word.password_second[KEY_BITS-1:0]);
        pw_match  = (i_in_word.password_first[KEY_BITS-1:0] == r_stored_pw);

        case (i_in_word.mode)
            pdlc_pkg::MODE_TICK: begin
                if (r_door_phase != pdlc_pkg::DOOR_IDLE) begin
                    n_door_timer = door_dec;
                    if (door_dec == 8'd0) begin
                        case (r_door_phase)
                            pdlc_pkg::DOOR_UNLOCK: begin
                                n_door_phase = pdlc_pkg::DOOR_HOLD;
                                n_door_timer = pdlc_pkg::at_least_one8(r_hold_ticks);
                            end
                            pdlc_pkg::DOOR_HOLD: begin
                                n_door_phase = pdlc_pkg::DOOR_LOCK;
                                n_door_timer = pdlc_pkg::at_least_one8(r_unlock_ticks);
                            end
                            default: begin
                                n_door_phase = pdlc_pkg::DOOR_IDLE;
                            end
                        endcase
                    end
                end
                if (r_alarm_active) begin
                    n_alarm_timer = alarm_dec;
                    if (alarm_dec == 8'd0) begin
                        n_alarm_active = 1'b0;
                    end
                end
            end
            pdlc_pkg::MODE_ENROLL: begin
                if (!r_enrolled) begin
                    if (key_eq) begin
                        n_stored_pw = i_in_word.password_first[KEY_BITS-1:0];
                        n_enrolled  = 1'b1;
                        reply       = pdlc_pkg::REPLY_CORRECT;
                    end else begin
                        reply = pdlc_pkg::REPLY_WRONG;
                    end
                end
            end
            pdlc_pkg::MODE_ATTEMPT: begin
                if (r_enrolled) begin
                    if (pw_match) begin
                        reply        = pdlc_pkg::REPLY_CORRECT;
                        n_miss_count = 3'd0;
                        if (i_in_word.choice == pdlc_pkg::CHOICE_OPEN) begin
                            // restarts the sequence even mid-motion
                            n_door_phase = pdlc_pkg::DOOR_UNLOCK;
                            n_door_timer = pdlc_pkg::at_least_one8(r_unlock_ticks);
                        end else if (i_in_word.choice == pdlc_pkg::CHOICE_CHANGE) begin
                            n_enrolled = 1'b0;
                        end
                    end else if (miss_next == 3'd0 ||
                                 miss_next >= pdlc_pkg::at_least_one3(r_attempt_limit)) begin
                        reply          = pdlc_pkg::REPLY_WRONG;
                        n_alarm_active = 1'b1;
                        n_alarm_timer  = pdlc_pkg::at_least_one8(r_alarm_ticks);
                        n_miss_count   = 3'd0;
                    end else begin
                        reply        = pdlc_pkg::REPLY_REPEAT;
                        n_miss_count = miss_next;
                    end
                end
            end
            default: ;   // unused mode: no change, no time passes
        endcase

        n_result.reply = reply;
        case (n_door_phase)
            pdlc_pkg::DOOR_UNLOCK: begin
                n_result.motor_direction = pdlc_pkg::DIR_UNLOCK;
                n_result.motor_speed     = pdlc_pkg::SPEED_UNLOCK;
            end
            pdlc_pkg::DOOR_LOCK: begin
                n_result.motor_direction = pdlc_pkg::DIR_LOCK;
                n_result.motor_speed     = pdlc_pkg::SPEED_LOCK;
            end
            default: begin
                n_result.motor_direction = pdlc_pkg::DIR_STOP;
                n_result.motor_speed     = pdlc_pkg::SPEED_STOP;
            end
        endcase
        n_result.alarm_sounding = n_alarm_active;
        n_result.enrolled_flag  = n_enrolled;
    end

    // Door sequence state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_phase <= pdlc_pkg::DOOR_IDLE;
        end else if (in_acc) begin
            r_door_phase <= n_door_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enrolled     <= 1'b0;
            r_miss_count   <= 3'd0;
            r_door_timer   <= 8'd0;
            r_alarm_active <= 1'b0;
            r_alarm_timer  <= 8'd0;
        end else if (in_acc) begin
            r_enrolled     <= n_enrolled;
            r_miss_count   <= n_miss_count;
            r_door_timer   <= n_door_timer;
            r_alarm_active <= n_alarm_active;
            r_alarm_timer  <= n_alarm_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stored_pw <= n_stored_pw;
        end
    end

    // Output register plus skid: skid fills only when a word arrives while
    // the output register holds a word that is not taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
            end else if (in_acc) begin
                r_out_word <= n_result;
            end
        end else if (in_acc) begin
            if (r_out_valid) begin
                r_skid_word <= n_result;
            end else begin
                r_out_word <= n_result;
            end
        end
    end

    // ---------------- assertions ----------------
    `ASSERT_NEVER(a_skid_without_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid)
    `ASSERT_CHK(a_door_timer_live, i_clk, i_rst_n,
        (r_door_phase != pdlc_pkg::DOOR_IDLE) |-> (r_door_timer != 8'd0))
    `ASSERT_CHK(a_alarm_timer_live, i_clk, i_rst_n,
        r_alarm_active |-> (r_alarm_timer != 8'd0))

endmodule
